### hdl/prs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_pkg: shared types and constants for the priority ready select block
// Table depth, field widths, request and status codes, entry layout.
// ----------------------------------------------------------------------------
package prs_pkg;

  localparam int READY_DEPTH = 64;
  localparam int IDX_W       = $clog2(READY_DEPTH);
  localparam int CNT_W       = $clog2(READY_DEPTH + 1);

  localparam int PRIO_W  = 8;
  localparam int ARR_W   = 32;
  localparam int ID_W    = 16;
  localparam int ENTRY_W = PRIO_W + ARR_W + ID_W;
  localparam int HELD_W  = 7;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 64;
  localparam int REQ_W      = 2;
  localparam int STAT_W     = 2;

  localparam logic [REQ_W-1:0] REQ_ENQ     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PICK    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PREEMPT = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // packed so that a plain unsigned compare gives priority, then arrival, then id
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [ARR_W-1:0]  arrival;
    logic [ID_W-1:0]   id;
  } entry_t;

endpackage

### hdl/priority_ready_select_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_ready_select_top: ready table with lowest-priority-number pick
// Enqueue, pick, preempt query and clear over a 64-entry task table.
// ----------------------------------------------------------------------------
// One request word in, one result word out. Enqueue, preempt query, clear and
// a pick from an empty table load the result register once accepted. A pick
// walks the held entries through the single read port of the table RAM, one
// entry and one 56-bit compare per cycle, then the drain and write states,
// before its result is presented. The next request is taken once the block
// is back in idle and the result register is empty or being drained.
module priority_ready_select_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // task_priority[7:0], task_arrival[39:8], task_id[55:40], running_priority[63:56]
  input  logic [prs_pkg::IN_DATA_W-1:0]   in_tdata,
  // req_type[1:0]
  input  logic [prs_pkg::REQ_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // chosen_id[15:0], chosen_priority[23:16], chosen_arrival[55:24], preempt[56],
  // entries_held[63:57]
  output logic [prs_pkg::OUT_DATA_W-1:0]  out_tdata,
  // status[1:0]
  output logic [prs_pkg::STAT_W-1:0]      out_tuser
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [prs_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [prs_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic cmp_vld_r, cmp_vld_nxt;
  logic [prs_pkg::IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  prs_pkg::entry_t best_r, best_nxt;
  logic [prs_pkg::IDX_W-1:0] best_idx_r, best_idx_nxt;
  prs_pkg::entry_t last_r, last_nxt;

  logic out_vld_r, out_vld_nxt;
  logic [prs_pkg::STAT_W-1:0] out_stat_r, out_stat_nxt;
  prs_pkg::entry_t out_ent_r, out_ent_nxt;
  logic out_pre_r, out_pre_nxt;
  logic [prs_pkg::HELD_W-1:0] out_held_r, out_held_nxt;

  prs_pkg::entry_t mem [prs_pkg::READY_DEPTH];
  prs_pkg::entry_t rd_data_r;
  logic [prs_pkg::IDX_W-1:0] rd_addr;
  logic wr_en;
  logic [prs_pkg::IDX_W-1:0] wr_addr;
  prs_pkg::entry_t wr_data;

  logic in_acc;
  logic [prs_pkg::REQ_W-1:0] req;
  prs_pkg::entry_t in_ent;
  logic [prs_pkg::PRIO_W-1:0] run_prio;
  logic [prs_pkg::CNT_W-1:0] last_pos;
  logic [prs_pkg::CNT_W+prs_pkg::HELD_W-1:0] held_ext;

  assign in_tready = (state_r == ST_IDLE) && (!out_vld_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign req       = in_tuser;
  assign in_ent.prio    = in_tdata[7:0];
  assign in_ent.arrival = in_tdata[39:8];
  assign in_ent.id      = in_tdata[55:40];
  assign run_prio       = in_tdata[63:56];
  assign last_pos       = count_r - prs_pkg::CNT_W'(1);
  assign held_ext       = {{prs_pkg::HELD_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    cmp_vld_nxt  = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    last_nxt     = last_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_stat_nxt = out_stat_r;
    out_ent_nxt  = out_ent_r;
    out_pre_nxt  = out_pre_r;
    rd_addr      = idx_r;
    wr_en        = 1'b0;
    wr_addr      = count_r[prs_pkg::IDX_W-1:0];
    wr_data      = in_ent;

    // compare stage: registered read data against the running best
    if (cmp_vld_r) begin
      if ((cmp_idx_r == '0) || (rd_data_r < best_r)) begin
        best_nxt     = rd_data_r;
        best_idx_nxt = cmp_idx_r;
      end
      if ({1'b0, cmp_idx_r} == last_pos) begin
        last_nxt = rd_data_r;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          out_stat_nxt = prs_pkg::STAT_OK;
          out_ent_nxt  = '0;
          out_pre_nxt  = 1'b0;
          unique case (req)
            prs_pkg::REQ_ENQ: begin
              out_vld_nxt = 1'b1;
              if (count_r < prs_pkg::CNT_W'(prs_pkg::READY_DEPTH)) begin
                wr_en     = 1'b1;
                count_nxt = count_r + prs_pkg::CNT_W'(1);
              end else begin
                out_stat_nxt = prs_pkg::STAT_FULL;
              end
            end
            prs_pkg::REQ_PICK: begin
              if (count_r == '0) begin
                out_vld_nxt  = 1'b1;
                out_stat_nxt = prs_pkg::STAT_EMPTY;
              end else begin
                idx_nxt   = '0;
                state_nxt = ST_SCAN;
              end
            end
            prs_pkg::REQ_PREEMPT: begin
              out_vld_nxt = 1'b1;
              out_pre_nxt = in_ent.prio < run_prio;
            end
            prs_pkg::REQ_CLEAR: begin
              out_vld_nxt = 1'b1;
              count_nxt   = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmp_vld_nxt = 1'b1;
        cmp_idx_nxt = idx_r;
        if ({1'b0, idx_r} == last_pos) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + prs_pkg::IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        wr_en        = 1'b1;
        wr_addr      = best_idx_r;
        wr_data      = last_r;
        count_nxt    = last_pos;
        out_vld_nxt  = 1'b1;
        out_stat_nxt = prs_pkg::STAT_OK;
        out_ent_nxt  = best_r;
        out_pre_nxt  = 1'b0;
        state_nxt    = ST_IDLE;
      end
      default: ;
    endcase

    out_held_nxt = out_held_r;
    if (out_vld_nxt && !(out_vld_r && !out_tready)) begin
      out_held_nxt = held_ext[prs_pkg::HELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    last_r     <= last_nxt;
    out_stat_r <= out_stat_nxt;
    out_ent_r  <= out_ent_nxt;
    out_pre_r  <= out_pre_nxt;
    out_held_r <= out_held_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = {out_held_r, out_pre_r, out_ent_r.arrival, out_ent_r.prio,
                       out_ent_r.id};

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for priority_ready_select_top
// Runs a short table of directed requests (empty pick, preempt extremes,
// tie-breaks, fill to full, clear), then biased random request streams that
// walk the table between empty and full. Every result word is checked field
// by field against the directed table or an in-bench scheduler model, under
// bursty input traffic and output stalls.
// ----------------------------------------------------------------------------
module tb;

  localparam int RAND_WORDS  = 1760;
  localparam int HOLD_AT     = 500;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_AT    = 1000;

  localparam logic [prs_pkg::REQ_W-1:0]  REQ_ENQ     = prs_pkg::REQ_ENQ;
  localparam logic [prs_pkg::REQ_W-1:0]  REQ_PICK    = prs_pkg::REQ_PICK;
  localparam logic [prs_pkg::REQ_W-1:0]  REQ_PREEMPT = prs_pkg::REQ_PREEMPT;
  localparam logic [prs_pkg::REQ_W-1:0]  REQ_CLEAR   = prs_pkg::REQ_CLEAR;
  localparam logic [prs_pkg::STAT_W-1:0] STAT_OK     = prs_pkg::STAT_OK;
  localparam logic [prs_pkg::STAT_W-1:0] STAT_FULL   = prs_pkg::STAT_FULL;
  localparam logic [prs_pkg::STAT_W-1:0] STAT_EMPTY  = prs_pkg::STAT_EMPTY;

  typedef enum int {BIAS_FILL, BIAS_DRAIN, BIAS_MIXED} bias_t;

  typedef struct packed {
    logic [prs_pkg::REQ_W-1:0]  req;
    logic [prs_pkg::PRIO_W-1:0] prio;
    logic [prs_pkg::ARR_W-1:0]  arr;
    logic [prs_pkg::ID_W-1:0]   id;
    logic [prs_pkg::PRIO_W-1:0] run;
  } request_t;

  typedef struct packed {
    logic [prs_pkg::STAT_W-1:0] status;
    logic [prs_pkg::ID_W-1:0]   id;
    logic [prs_pkg::PRIO_W-1:0] prio;
    logic [prs_pkg::ARR_W-1:0]  arr;
    logic                       pre;
    logic [prs_pkg::HELD_W-1:0] held;
  } result_t;

  // typed rows carry status, preempt and count; their chosen fields are zero
  typedef struct packed {
    logic [prs_pkg::REQ_W-1:0]  req;
    logic [prs_pkg::PRIO_W-1:0] prio;
    logic [prs_pkg::ARR_W-1:0]  arr;
    logic [prs_pkg::ID_W-1:0]   id;
    logic [prs_pkg::PRIO_W-1:0] run;
    logic [7:0]                 rep;
    logic                       typed;
    logic [prs_pkg::STAT_W-1:0] status;
    logic                       pre;
    logic [prs_pkg::HELD_W-1:0] held;
  } step_t;

  localparam int N_DIRECTED = 25;
  localparam step_t DIRECTED [N_DIRECTED] = '{
    '{REQ_PICK,    8'd0,   32'h0,        16'h0,    8'd0,   8'd1,  1'b1, STAT_EMPTY, 1'b0, 7'd0},
    '{REQ_PREEMPT, 8'd0,   32'h0,        16'h0,    8'd255, 8'd1,  1'b1, STAT_OK,    1'b1, 7'd0},
    '{REQ_PREEMPT, 8'd255, 32'hFFFFFFFF, 16'hFFFF, 8'd0,   8'd1,  1'b1, STAT_OK,    1'b0, 7'd0},
    '{REQ_PREEMPT, 8'd77,  32'h0,        16'h0,    8'd77,  8'd1,  1'b1, STAT_OK,    1'b0, 7'd0},
    '{REQ_CLEAR,   8'd0,   32'h0,        16'h0,    8'd0,   8'd1,  1'b1, STAT_OK,    1'b0, 7'd0},
    '{REQ_ENQ,     8'd255, 32'hFFFFFFFF, 16'hFFFF, 8'd255, 8'd1,  1'b1, STAT_OK,    1'b0, 7'd1},
    '{REQ_ENQ,     8'd0,   32'h0,        16'h0,    8'd0,   8'd1,  1'b1, STAT_OK,    1'b0, 7'd2},
    '{REQ_ENQ,     8'd10,  32'd100,      16'd5,    8'd0,   8'd1,  1'b1, STAT_OK,    1'b0, 7'd3},
    '{REQ_ENQ,     8'd10,  32'd50,       16'd9,    8'd0,   8'd1,  1'b1, STAT_OK,    1'b0, 7'd4},
    '{REQ_ENQ,     8'd10,  32'd50,       16'd3,    8'd0,   8'd1,  1'b1, STAT_OK,    1'b0, 7'd5},
    '{REQ_PICK,    8'd0,   32'h0,        16'h0,    8'd0,   8'd1,  1'b1, STAT_OK,    1'b0, 7'd4},
    '{REQ_PICK,    8'd0,   32'h0,        16'h0,    8'd0,   8'd1,  1'b0, STAT_OK,    1'b0, 7'd0},
    '{REQ_PICK,    8'd0,   32'h0,        16'h0,    8'd0,   8'd1,  1'b0, STAT_OK,    1'b0, 7'd0},
    '{REQ_PICK,    8'd0,   32'h0,        16'h0,    8'd0,   8'd1,  1'b0, STAT_OK,    1'b0, 7'd0},
    '{REQ_PICK,    8'd0,   32'h0,        16'h0,    8'd0,   8'd1,  1'b0, STAT_OK,    1'b0, 7'd0},
    '{REQ_PICK,    8'd0,   32'h0,        16'h0,    8'd0,   8'd1,  1'b1, STAT_EMPTY, 1'b0, 7'd0},
    '{REQ_ENQ,     8'd128, 32'hA5A5A5A5, 16'h5A5A, 8'd0,   8'd64, 1'b0, STAT_OK,    1'b0, 7'd0},
    '{REQ_ENQ,     8'd1,   32'd2,        16'd3,    8'd4,   8'd1,  1'b1, STAT_FULL,  1'b0, 7'd64},
    '{REQ_PREEMPT, 8'd1,   32'h0,        16'h0,    8'd2,   8'd1,  1'b1, STAT_OK,    1'b1, 7'd64},
    '{REQ_PICK,    8'd0,   32'h0,        16'h0,    8'd0,   8'd1,  1'b0, STAT_OK,    1'b0, 7'd0},
    '{REQ_ENQ,     8'd200, 32'd7,        16'd7,    8'd0,   8'd1,  1'b1, STAT_OK,    1'b0, 7'd64},
    '{REQ_PICK,    8'd0,   32'h0,        16'h0,    8'd0,   8'd1,  1'b0, STAT_OK,    1'b0, 7'd0},
    '{REQ_CLEAR,   8'd0,   32'h0,        16'h0,    8'd0,   8'd1,  1'b1, STAT_OK,    1'b0, 7'd0},
    '{REQ_PICK,    8'd0,   32'h0,        16'h0,    8'd0,   8'd1,  1'b1, STAT_EMPTY, 1'b0, 7'd0},
    '{REQ_ENQ,     8'd3,   32'd3,        16'd3,    8'd3,   8'd1,  1'b0, STAT_OK,    1'b0, 7'd0}
  };

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [prs_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [prs_pkg::REQ_W-1:0]      in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [prs_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [prs_pkg::STAT_W-1:0]     out_tuser;

  priority_ready_select_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  prs_pkg::entry_t ready_tbl [prs_pkg::READY_DEPTH];
  int      ready_cnt = 0;
  result_t pending_results [$];
  bit      failed = 1'b0;
  int      results_seen = 0;
  int      burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic result_t schedule_request(input request_t rq);
    result_t r;
    int      best;
    r = '0;
    case (rq.req)
      REQ_ENQ: begin
        if (ready_cnt < prs_pkg::READY_DEPTH) begin
          ready_tbl[ready_cnt] = '{prio: rq.prio, arrival: rq.arr, id: rq.id};
          ready_cnt++;
        end else begin
          r.status = STAT_FULL;
        end
      end
      REQ_PICK: begin
        if (ready_cnt == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          best = 0;
          // entry_t packs prio, arrival, id from the top: one compare orders all three
          for (int i = 1; i < ready_cnt; i++)
            if (ready_tbl[i] < ready_tbl[best]) best = i;
          r.id   = ready_tbl[best].id;
          r.prio = ready_tbl[best].prio;
          r.arr  = ready_tbl[best].arrival;
          ready_cnt--;
          ready_tbl[best] = ready_tbl[ready_cnt];
        end
      end
      REQ_PREEMPT: r.pre = (rq.prio < rq.run);
      REQ_CLEAR:   ready_cnt = 0;
      default: ;
    endcase
    r.held = prs_pkg::HELD_W'(ready_cnt);
    return r;
  endfunction

  function automatic request_t random_request(input bias_t bias);
    request_t rq;
    int       roll;
    int       enq_lim;
    int       pick_lim;
    int       pre_lim;
    rq.prio = $urandom_range(0, 1) ? prs_pkg::PRIO_W'($urandom)
                                   : prs_pkg::PRIO_W'($urandom_range(0, 3));
    rq.arr  = $urandom_range(0, 1) ? prs_pkg::ARR_W'($urandom)
                                   : prs_pkg::ARR_W'($urandom_range(0, 3));
    rq.id   = $urandom_range(0, 1) ? prs_pkg::ID_W'($urandom)
                                   : prs_pkg::ID_W'($urandom_range(0, 3));
    rq.run  = prs_pkg::PRIO_W'($urandom);
    case (bias)
      BIAS_FILL:  begin enq_lim = 75; pick_lim = 90; pre_lim = 100; end
      BIAS_DRAIN: begin enq_lim = 20; pick_lim = 85; pre_lim = 99;  end
      default:    begin enq_lim = 45; pick_lim = 85; pre_lim = 99;  end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < enq_lim)       rq.req = REQ_ENQ;
    else if (roll < pick_lim) rq.req = REQ_PICK;
    else if (roll < pre_lim)  rq.req = REQ_PREEMPT;
    else                      rq.req = REQ_CLEAR;
    return rq;
  endfunction

  task automatic send_word(input request_t rq, input bit typed, input result_t typed_res);
    result_t pred;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= rq.req;
    in_tdata  <= {rq.run, rq.id, rq.arr, rq.prio};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = schedule_request(rq);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      failed = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      got = {out_tuser, out_tdata[15:0], out_tdata[23:16], out_tdata[55:24],
             out_tdata[56], out_tdata[63:57]};
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: 0x%0h", got);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        check_field("status",          32'(want.status), 32'(got.status));
        check_field("chosen_id",       32'(want.id),     32'(got.id));
        check_field("chosen_priority", 32'(want.prio),   32'(got.prio));
        check_field("chosen_arrival",  want.arr,         got.arr);
        check_field("preempt",         32'(want.pre),    32'(got.pre));
        check_field("entries_held",    32'(want.held),   32'(got.held));
      end
    end
  end

  // output side: free-running, light and heavy stall phases, one long hold-off
  initial begin
    int cyc;
    int hold_left;
    bit hold_done;
    cyc        = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case ((cyc / 400) % 3)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  initial begin
    request_t rq;
    result_t  typed_res;
    bias_t    bias;
    int       phase_left;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = REQ_ENQ;
    bias       = BIAS_FILL;
    phase_left = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < N_DIRECTED; k++) begin
      for (int j = 0; j < DIRECTED[k].rep; j++) begin
        rq = '{req: DIRECTED[k].req, prio: DIRECTED[k].prio, arr: DIRECTED[k].arr,
               id: DIRECTED[k].id, run: DIRECTED[k].run};
        typed_res = '{status: DIRECTED[k].status, id: '0, prio: '0, arr: '0,
                      pre: DIRECTED[k].pre, held: DIRECTED[k].held};
        pace();
        send_word(rq, DIRECTED[k].typed, typed_res);
      end
    end

    for (int n = 0; n < RAND_WORDS; n++) begin
      if (phase_left == 0) begin
        bias       = bias_t'($urandom_range(0, 2));
        phase_left = $urandom_range(40, 160);
      end
      phase_left--;
      if (n == DRAIN_AT) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      pace();
      send_word(random_request(bias), 1'b0, '0);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4 * prs_pkg::READY_DEPTH) @(posedge clk);
    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
